### rtl/core/pon_pkg.sv
// ============================================================================
// pon_pkg
// Shared types, constants and the sine table for the oscillator network core.
// ============================================================================
package pon_pkg;

    // Program store geometry
    localparam int MAX_SLOTS = 64;
    localparam int SLOT_W    = $clog2(MAX_SLOTS);
    localparam int CNT_W     = 7;   // width of var_count / program_length

    // Sine table geometry
    localparam int SINE_TABLE_BITS = 10;
    localparam int SINE_SIZE       = 1 << SINE_TABLE_BITS;
    localparam int QUARTER         = SINE_SIZE >> 2;
    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

    // Register reset values
    localparam logic [CNT_W-1:0] VAR_COUNT_RESET      = 7'd0;
    localparam logic [CNT_W-1:0] PROGRAM_LENGTH_RESET = 7'd1;
    localparam logic [31:0]      PHASE_STEP_RESET     = 32'd97391;

    typedef logic signed [31:0] sample_t;
    typedef sample_t sine_rom_t [SINE_SIZE];

    // Request kinds
    typedef enum logic [1:0] {
        REQ_PROG = 2'd0,
        REQ_VAR  = 2'd1,
        REQ_TICK = 2'd2
    } req_type_t;

    // Instruction opcodes
    typedef enum logic [1:0] {
        OP_VAR  = 2'd0,
        OP_SINE = 2'd1,
        OP_MUL  = 2'd2,
        OP_ADD  = 2'd3
    } opcode_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_VAR_COUNT      = 2'd0,
        CFG_PROGRAM_LENGTH = 2'd1,
        CFG_PHASE_STEP     = 2'd2
    } cfg_index_t;

    // One instruction slot
    typedef struct packed {
        opcode_t           op;
        logic [SLOT_W-1:0] a;
        logic [SLOT_W-1:0] b;
    } instr_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_DECODE,
        ST_EXEC,
        ST_WB,
        ST_SINE,
        ST_OUT_RD,
        ST_OUT
    } state_t;

    // sin of r/SINE_SIZE turns, r in 0..QUARTER, Q16.16; Taylor series in Q30
    function automatic sample_t quarter_sine(input logic [31:0] r);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        rounded;
        x    = ({32'd0, r} * TWO_PI_Q30 + 64'(SINE_SIZE >> 1)) >> SINE_TABLE_BITS;
        x2   = (x * x) >> 30;
        term = x;
        sum  = signed'(x);
        term = ((term * x2) >> 30) / 64'd6;   sum = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd20;  sum = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd42;  sum = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd72;  sum = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd110; sum = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd156; sum = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd210; sum = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd272; sum = sum + signed'(term);
        if (sum < 0)
        begin
            sum = '0;
        end
        rounded = unsigned'(sum) + 64'd8192;
        return signed'(rounded[45:14]);
    endfunction

    // Full-turn table built from quarter-wave symmetry
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t   rom;
        sample_t     s;
        int unsigned q;
        int unsigned r;
        for (int k = 0; k < SINE_SIZE; k++)
        begin
            q = k / QUARTER;
            r = k % QUARTER;
            s = q[0] ? quarter_sine(32'(QUARTER - r)) : quarter_sine(32'(r));
            rom[k] = q[1] ? -s : s;
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

### rtl/core/programmable_oscillator_network.sv
// ============================================================================
// programmable_oscillator_network
// Small per-sample synthesis engine: program slots hold variables, sine
// oscillators, multiplies and adds; one shared multiplier walks the program.
// ============================================================================
//
//  Channel | Direction | Handshake           | Payload
//  --------+-----------+---------------------+------------------------------------
//  in      | input     | in_valid / in_stall | req_type, slot, opcode, operand_a,
//          |           |                     | operand_b, value
//  out     | output    | out_valid/out_stall | sample
//  cfg     | input     | cfg_we              | cfg_index, cfg_data
//
//  Program and variable write requests are taken in the idle state. A tick runs
//  fetch, decode, execute and write-back per executed slot, plus a sine state for
//  a sine slot, then output read and output; the slot loop is set by the shared
//  multiplier and the registered slot memory reads, and the sine state covers the
//  registered sine table read. Reset clears the control and configuration
//  registers and the valid bits of the value and phase stores; no clearing pass
//  is needed. A result waits in the output register while further requests are
//  taken; a following tick holds at its end until that result has left.

module programmable_oscillator_network
(
    input  logic                              clk,
    input  logic                              rst_n,

    // Request channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        req_type,
    input  logic [pon_pkg::SLOT_W-1:0]        slot,
    input  logic [1:0]                        opcode,
    input  logic [pon_pkg::SLOT_W-1:0]        operand_a,
    input  logic [pon_pkg::SLOT_W-1:0]        operand_b,
    input  logic signed [31:0]                value,

    // Result channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [31:0]                sample,

    // Configuration port
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_index,
    input  logic [31:0]                       cfg_data
);

    localparam int SW = pon_pkg::SLOT_W;
    localparam int CW = pon_pkg::CNT_W;

    // ------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------
    pon_pkg::state_t state_reg, state_next;

    logic [CW-1:0]    var_count_reg;
    logic [CW-1:0]    program_length_reg;
    logic [31:0]      phase_step_reg;

    logic [CW-1:0]    pc_reg, pc_next;
    logic [CW-1:0]    len_reg;
    logic [CW-1:0]    len_clamped;
    logic             pc_last;

    logic signed [65:0] prod_reg;
    pon_pkg::sample_t sine_reg;
    logic             out_valid_reg;
    pon_pkg::sample_t sample_reg;

    // Memories
    pon_pkg::instr_t  ins_mem [pon_pkg::MAX_SLOTS];
    pon_pkg::sample_t val_mem [pon_pkg::MAX_SLOTS];
    logic [31:0]      ph_mem  [pon_pkg::MAX_SLOTS];
    logic [pon_pkg::MAX_SLOTS-1:0] val_ok_reg;
    logic [pon_pkg::MAX_SLOTS-1:0] ph_ok_reg;

    // Registered read data
    pon_pkg::instr_t  ins_q;
    pon_pkg::sample_t rd_a_q, rd_b_q;
    logic             rd_a_ok, rd_b_ok;
    logic [31:0]      ph_q;
    logic             ph_ok;

    // Port control
    logic             in_accept;
    logic             ins_we;
    logic             val_we;
    logic [SW-1:0]    val_waddr;
    pon_pkg::sample_t val_wdata;
    logic             ph_we;
    logic [SW-1:0]    ph_waddr;
    logic [31:0]      ph_wdata;
    logic [SW-1:0]    rd_a_addr;
    logic             out_load;
    logic             pc_step;

    // Datapath
    pon_pkg::sample_t op_a, op_b;
    logic [31:0]      ph_val;
    logic [31:0]      ph_sum;
    logic signed [32:0] mul_b;
    logic signed [65:0] prod_next;
    logic signed [32:0] sum33;
    pon_pkg::sample_t add_sat;
    pon_pkg::sample_t mul_sat;
    pon_pkg::instr_t  ins_wdata;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            var_count_reg      <= pon_pkg::VAR_COUNT_RESET;
            program_length_reg <= pon_pkg::PROGRAM_LENGTH_RESET;
            phase_step_reg     <= pon_pkg::PHASE_STEP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (pon_pkg::cfg_index_t'(cfg_index))
                pon_pkg::CFG_VAR_COUNT:      var_count_reg      <= cfg_data[CW-1:0];
                pon_pkg::CFG_PROGRAM_LENGTH: program_length_reg <= cfg_data[CW-1:0];
                pon_pkg::CFG_PHASE_STEP:     phase_step_reg     <= cfg_data;
                default:                     ;
            endcase
        end
    end

    // Length clamped to 1..MAX_SLOTS
    always_comb
    begin
        if (program_length_reg == '0)
            len_clamped = CW'(1);
        else if (program_length_reg > CW'(pon_pkg::MAX_SLOTS))
            len_clamped = CW'(pon_pkg::MAX_SLOTS);
        else
            len_clamped = program_length_reg;
    end

    assign in_accept = in_valid && !in_stall;
    assign pc_last   = (pc_reg + CW'(1)) >= len_reg;

    // ------------------------------------------------------------------
    // Operand masking and shared arithmetic
    // ------------------------------------------------------------------
    assign op_a   = rd_a_ok ? rd_a_q : '0;
    assign op_b   = rd_b_ok ? rd_b_q : '0;
    assign ph_val = ph_ok ? ph_q : '0;

    // Shared multiplier: frequency times step for sine, a times b otherwise
    assign mul_b     = (ins_q.op == pon_pkg::OP_SINE) ? $signed({1'b0, phase_step_reg})
                                                      : $signed({op_b[31], op_b});
    assign prod_next = $signed({op_a[31], op_a}) * mul_b;

    // Saturated Q16.16 product: floor shift, clip when top bits disagree
    always_comb
    begin
        if ((&prod_reg[65:47]) || !(|prod_reg[65:47]))
            mul_sat = prod_reg[47:16];
        else if (prod_reg[65])
            mul_sat = 32'sh8000_0000;
        else
            mul_sat = 32'sh7FFF_FFFF;
    end

    // Saturated add
    assign sum33 = $signed({op_a[31], op_a}) + $signed({op_b[31], op_b});
    always_comb
    begin
        if (sum33[32] == sum33[31])
            add_sat = sum33[31:0];
        else if (sum33[32])
            add_sat = 32'sh8000_0000;
        else
            add_sat = 32'sh7FFF_FFFF;
    end

    // Phase advance
    assign ph_sum = ph_val + prod_reg[47:16];

    assign ins_wdata.op = pon_pkg::opcode_t'(opcode);
    assign ins_wdata.a  = operand_a;
    assign ins_wdata.b  = operand_b;

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pon_pkg::ST_IDLE:
            begin
                if (in_accept && (pon_pkg::req_type_t'(req_type) == pon_pkg::REQ_TICK))
                begin
                    if (var_count_reg < len_clamped)
                        state_next = pon_pkg::ST_FETCH;
                    else
                        state_next = pon_pkg::ST_OUT_RD;
                end
            end
            pon_pkg::ST_FETCH:  state_next = pon_pkg::ST_DECODE;
            pon_pkg::ST_DECODE: state_next = pon_pkg::ST_EXEC;
            pon_pkg::ST_EXEC:   state_next = pon_pkg::ST_WB;
            pon_pkg::ST_WB:
            begin
                if (ins_q.op == pon_pkg::OP_SINE)
                    state_next = pon_pkg::ST_SINE;
                else if (pc_last)
                    state_next = pon_pkg::ST_OUT_RD;
                else
                    state_next = pon_pkg::ST_FETCH;
            end
            pon_pkg::ST_SINE:
            begin
                if (pc_last)
                    state_next = pon_pkg::ST_OUT_RD;
                else
                    state_next = pon_pkg::ST_FETCH;
            end
            pon_pkg::ST_OUT_RD: state_next = pon_pkg::ST_OUT;
            pon_pkg::ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                    state_next = pon_pkg::ST_IDLE;
            end
            default:            state_next = pon_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        in_stall  = 1'b1;
        ins_we    = 1'b0;
        val_we    = 1'b0;
        val_waddr = pc_reg[SW-1:0];
        val_wdata = mul_sat;
        ph_we     = 1'b0;
        ph_waddr  = pc_reg[SW-1:0];
        ph_wdata  = ph_sum;
        rd_a_addr = ins_q.a;
        out_load  = 1'b0;
        pc_step   = 1'b0;
        unique case (state_reg)
            pon_pkg::ST_IDLE:
            begin
                in_stall  = 1'b0;
                val_waddr = slot;
                ph_waddr  = slot;
                val_wdata = value;
                ph_wdata  = '0;
                if (in_valid)
                begin
                    unique case (pon_pkg::req_type_t'(req_type))
                        pon_pkg::REQ_PROG:
                        begin
                            ins_we = 1'b1;
                            val_we = 1'b1;
                            ph_we  = 1'b1;
                            if (pon_pkg::opcode_t'(opcode) != pon_pkg::OP_VAR)
                                val_wdata = '0;
                        end
                        pon_pkg::REQ_VAR:
                        begin
                            val_we = ({1'b0, slot} < var_count_reg);
                        end
                        default: ;
                    endcase
                end
            end
            pon_pkg::ST_WB:
            begin
                unique case (ins_q.op)
                    pon_pkg::OP_SINE: ph_we = 1'b1;
                    pon_pkg::OP_MUL:
                    begin
                        val_we    = 1'b1;
                        val_wdata = mul_sat;
                    end
                    pon_pkg::OP_ADD:
                    begin
                        val_we    = 1'b1;
                        val_wdata = add_sat;
                    end
                    default: ;
                endcase
                pc_step = (ins_q.op != pon_pkg::OP_SINE);
            end
            pon_pkg::ST_SINE:
            begin
                val_we    = 1'b1;
                val_wdata = sine_reg;
                pc_step   = 1'b1;
            end
            pon_pkg::ST_OUT_RD:
            begin
                rd_a_addr = SW'(len_reg - CW'(1));
            end
            pon_pkg::ST_OUT:
            begin
                // hold the output slot address so the read data stays put
                rd_a_addr = SW'(len_reg - CW'(1));
                out_load  = !out_valid_reg || !out_stall;
            end
            default: ;
        endcase
    end

    assign pc_next = pc_reg + CW'(1);

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pon_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            pc_reg        <= '0;
            len_reg       <= CW'(1);
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            if (state_reg == pon_pkg::ST_IDLE)
            begin
                pc_reg  <= var_count_reg;
                len_reg <= len_clamped;
            end
            else if (pc_step)
            begin
                pc_reg <= pc_next;
            end
        end
    end

    // Valid bits of the value and phase stores
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_ok_reg <= '0;
            ph_ok_reg  <= '0;
        end
        else
        begin
            if (val_we)
                val_ok_reg[val_waddr] <= 1'b1;
            if (ph_we)
                ph_ok_reg[ph_waddr] <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (state_reg == pon_pkg::ST_EXEC)
            prod_reg <= prod_next;
        if (out_load)
            sample_reg <= op_a;
    end

    // Sine table: registered read, addressed by the top bits of the new phase
    always_ff @(posedge clk)
    begin
        if (state_reg == pon_pkg::ST_WB)
            sine_reg <= pon_pkg::SINE_ROM[ph_sum[31 -: pon_pkg::SINE_TABLE_BITS]];
    end

    // ------------------------------------------------------------------
    // Slot memories: one write port, registered reads
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (ins_we)
            ins_mem[slot] <= ins_wdata;
        ins_q <= ins_mem[pc_reg[SW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (val_we)
            val_mem[val_waddr] <= val_wdata;
        rd_a_q  <= val_mem[rd_a_addr];
        rd_b_q  <= val_mem[ins_q.b];
        rd_a_ok <= val_ok_reg[rd_a_addr];
        rd_b_ok <= val_ok_reg[ins_q.b];
    end

    always_ff @(posedge clk)
    begin
        if (ph_we)
            ph_mem[ph_waddr] <= ph_wdata;
        ph_q  <= ph_mem[pc_reg[SW-1:0]];
        ph_ok <= ph_ok_reg[pc_reg[SW-1:0]];
    end

    // ------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------
    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;

endmodule
